// ===== rtl/gcib_pkg.sv =====
// Package for the initial bearing unit: widths, CORDIC angle table and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gcib_pkg;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int LAT_W = 24;
	localparam int LON_W = 25;
	localparam int BRG_W = 25;
	localparam int STEPS = 30;
	localparam int ANG_W = 44;	// degrees, 32 fraction bits, covers +-2048
	localparam int VEC_W = 34;	// Q30 with headroom for CORDIC growth
	localparam int QDEPTH = 4;

	localparam logic [1:0] REG_REF_LAT = 2'd0;
	localparam logic [1:0] REG_REF_LON = 2'd1;

	localparam logic signed [ANG_W-1:0] DEG_90 = ANG_W'(64'sd90 <<< 32);
	localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(64'sd180 <<< 32);
	localparam logic signed [ANG_W-1:0] DEG_360 = ANG_W'(64'sd360 <<< 32);
	localparam logic signed [VEC_W-1:0] GAIN_Q30 = VEC_W'(652032874);
	localparam logic [63:0] RAD_TO_DEG_Q28 = 64'd15380218700;

	function automatic logic signed [ANG_W-1:0] step_angle(input int i);
		logic [63:0] sum;
		logic [63:0] term;
		logic [127:0] prod;
		int e;
		int k;
		sum = '0;
		k = 0;
		if (i == 0) begin
			return ANG_W'(64'sd45 <<< 32);
		end
		for (e = 62 - i; e >= 0; e = e - 2 * i) begin
			term = (64'd1 << e) / 64'(2 * k + 1);
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
			k = k + 1;
		end
		prod = 128'(sum >> 32) * 128'(RAD_TO_DEG_Q28);
		return ANG_W'(prod >> 26);
	endfunction

	typedef struct packed {
		logic signed [LAT_W-1:0] lat2;
		logic signed [LON_W:0] dlon;
	} item_t;
endpackage
`default_nettype wire

// ===== rtl/gcib_front.sv =====
// Front end: takes requests, forms internal angles and folds them for CORDIC.
// Uses gcib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcib_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire gcib_pkg::item_t in_item,
	input wire logic signed [gcib_pkg::LAT_W-1:0] ref_lat,
	output logic out_valid,
	output logic signed [gcib_pkg::ANG_W-1:0] a_s1 [3],
	output logic neg_s1 [3]
);
	localparam int SH = 32 - gcib_pkg::ANGLE_FRAC_BITS;

	logic signed [gcib_pkg::ANG_W-1:0] raw [3];
	logic signed [gcib_pkg::ANG_W-1:0] w0 [3];
	logic signed [gcib_pkg::ANG_W-1:0] w1 [3];
	logic signed [gcib_pkg::ANG_W-1:0] fz [3];
	logic fneg [3];

	always_comb begin
		raw[0] = gcib_pkg::ANG_W'(ref_lat) <<< SH;
		raw[1] = gcib_pkg::ANG_W'(in_item.lat2) <<< SH;
		raw[2] = gcib_pkg::ANG_W'(in_item.dlon) <<< SH;
		for (int k = 0; k < 3; k++) begin
			// inputs lie within +-2^9 degrees, so a few 360 steps reach [-180,180)
			w0[k] = raw[k];
			for (int r = 0; r < 3; r++) begin
				if (w0[k] >= gcib_pkg::DEG_180) begin
					w0[k] = w0[k] - gcib_pkg::DEG_360;
				end else if (w0[k] < -gcib_pkg::DEG_180) begin
					w0[k] = w0[k] + gcib_pkg::DEG_360;
				end
			end
			w1[k] = w0[k];
			fneg[k] = 1'b0;
			if (w1[k] > gcib_pkg::DEG_90) begin
				w1[k] = w1[k] - gcib_pkg::DEG_180;
				fneg[k] = 1'b1;
			end else if (w1[k] < -gcib_pkg::DEG_90) begin
				w1[k] = w1[k] + gcib_pkg::DEG_180;
				fneg[k] = 1'b1;
			end
			fz[k] = w1[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			a_s1[k] <= fz[k];
			neg_s1[k] <= fneg[k];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gcib_queue.sv =====
// Short FIFO between front and back ends; holds folded angles per request.
// Uses gcib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcib_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [3*gcib_pkg::ANG_W+2:0] wr_data,
	output logic rd_valid,
	output logic [3*gcib_pkg::ANG_W+2:0] rd_data
);
	localparam int AW = $clog2(gcib_pkg::QDEPTH);
	logic [3*gcib_pkg::ANG_W+2:0] mem_q [gcib_pkg::QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	// back end never stalls, so the queue drains one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			rd_valid <= 1'b0;
		end else begin
			rd_valid <= 1'b0;
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (cnt_q != '0) begin
				rp_q <= rp_q + 1'b1;
				rd_valid <= 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(cnt_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
		rd_data <= mem_q[rp_q];
	end
endmodule
`default_nettype wire

// ===== rtl/gcib_back.sv =====
// Back end: pipelined CORDIC sine/cosine, products, CORDIC atan2 and wrap.
// Uses gcib_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gcib_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [3*gcib_pkg::ANG_W+2:0] in_data,
	output logic out_valid,
	output logic [gcib_pkg::BRG_W-1:0] bearing
);
	localparam int N = gcib_pkg::STEPS;
	localparam int VW = gcib_pkg::VEC_W;
	localparam int AW = gcib_pkg::ANG_W;
	localparam int PW = 2 * VW;
	localparam int SH = 32 - gcib_pkg::ANGLE_FRAC_BITS;

	// rotation pipeline, three lanes
	logic signed [VW-1:0] rx_q [N+1][3];
	logic signed [VW-1:0] ry_q [N+1][3];
	logic signed [AW-1:0] rz_q [N+1][3];
	logic rn_q [N+1][3];
	logic rv_q [N+1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rx_q[0][k] = gcib_pkg::GAIN_Q30;
			ry_q[0][k] = '0;
			rz_q[0][k] = AW'(in_data[k*(AW+1)+1 +: AW]);
			rn_q[0][k] = in_data[k*(AW+1)];
		end
		rv_q[0] = in_valid;
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam logic signed [AW-1:0] T = gcib_pkg::step_angle(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_q[i+1] <= 1'b0;
			end else begin
				rv_q[i+1] <= rv_q[i];
			end
		end
		always_ff @(posedge clk) begin
			for (int k = 0; k < 3; k++) begin
				rn_q[i+1][k] <= rn_q[i][k];
				if (rz_q[i][k] >= 0) begin
					rx_q[i+1][k] <= rx_q[i][k] - (ry_q[i][k] >>> i);
					ry_q[i+1][k] <= ry_q[i][k] + (rx_q[i][k] >>> i);
					rz_q[i+1][k] <= rz_q[i][k] - T;
				end else begin
					rx_q[i+1][k] <= rx_q[i][k] + (ry_q[i][k] >>> i);
					ry_q[i+1][k] <= ry_q[i][k] - (rx_q[i][k] >>> i);
					rz_q[i+1][k] <= rz_q[i][k] + T;
				end
			end
		end
	end

	// lane 0: lat1, lane 1: lat2, lane 2: dlon
	logic signed [VW-1:0] s1, c1, s2, c2, sd, cd;
	always_comb begin
		s1 = rn_q[N][0] ? -ry_q[N][0] : ry_q[N][0];
		c1 = rn_q[N][0] ? -rx_q[N][0] : rx_q[N][0];
		s2 = rn_q[N][1] ? -ry_q[N][1] : ry_q[N][1];
		c2 = rn_q[N][1] ? -rx_q[N][1] : rx_q[N][1];
		sd = rn_q[N][2] ? -ry_q[N][2] : ry_q[N][2];
		cd = rn_q[N][2] ? -rx_q[N][2] : rx_q[N][2];
	end

	// product stages
	logic signed [VW-1:0] y_s1, a_s1, b_s1, cd_s1, y_s2, x_s2;
	logic signed [PW-1:0] p_y, p_a, p_b, p_x;
	logic v_s1, v_s2;
	always_comb begin
		p_y = PW'(sd) * PW'(c2);
		p_a = PW'(c1) * PW'(s2);
		p_b = PW'(s1) * PW'(c2);
		p_x = PW'(b_s1) * PW'(cd_s1);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rv_q[N];
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		y_s1 <= VW'(p_y >>> 30);
		a_s1 <= VW'(p_a >>> 30);
		b_s1 <= VW'(p_b >>> 30);
		cd_s1 <= cd;
		y_s2 <= y_s1;
		x_s2 <= a_s1 - VW'(p_x >>> 30);
	end

	// vectoring pipeline
	logic signed [VW+1:0] vx_q [N+1];
	logic signed [VW+1:0] vy_q [N+1];
	logic signed [AW-1:0] vz_q [N+1];
	logic vzero_q [N+1];
	logic vv_q [N+1];

	always_comb begin
		vzero_q[0] = (x_s2 == 0) && (y_s2 == 0);
		vv_q[0] = v_s2;
		vx_q[0] = (VW+2)'(x_s2);
		vy_q[0] = (VW+2)'(y_s2);
		vz_q[0] = '0;
		if (x_s2 < 0) begin
			if (y_s2 >= 0) begin
				vx_q[0] = (VW+2)'(y_s2);
				vy_q[0] = -(VW+2)'(x_s2);
				vz_q[0] = gcib_pkg::DEG_90;
			end else begin
				vx_q[0] = -(VW+2)'(y_s2);
				vy_q[0] = (VW+2)'(x_s2);
				vz_q[0] = -gcib_pkg::DEG_90;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic signed [AW-1:0] T = gcib_pkg::step_angle(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_q[i+1] <= 1'b0;
			end else begin
				vv_q[i+1] <= vv_q[i];
			end
		end
		always_ff @(posedge clk) begin
			vzero_q[i+1] <= vzero_q[i];
			if (vy_q[i] >= 0) begin
				vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
				vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
				vz_q[i+1] <= vz_q[i] + T;
			end else begin
				vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
				vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
				vz_q[i+1] <= vz_q[i] - T;
			end
		end
	end

	// wrap, round, reduce
	logic signed [AW-1:0] zp;
	logic [AW-1:0] rb;
	logic [AW-1:0] full;
	always_comb begin
		zp = vzero_q[N] ? '0 : vz_q[N];
		if (zp < 0) begin
			zp = zp + gcib_pkg::DEG_360;
		end
		rb = (AW'(zp) + (AW'(1) << (SH - 1))) >> SH;
		full = AW'(360) << gcib_pkg::ANGLE_FRAC_BITS;
		if (rb >= full) begin
			rb = rb - full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vv_q[N];
		end
	end
	always_ff @(posedge clk) begin
		bearing <= gcib_pkg::BRG_W'(rb);
	end
endmodule
`default_nettype wire

// ===== rtl/great_circle_initial_bearing_unit.sv =====
// Initial great-circle bearing from a configured reference point.
// Path: front end, queue, sin/cos CORDIC, product stages, atan2 CORDIC, output register.
// Throughput: one request per cycle; busy stays low, both CORDIC chains are fully pipelined.
// Result strobe is single-cycle; the receiver cannot stall, so the queue never fills.
// Reset (arst_n, asynchronous) clears valid flags and reference registers to 0.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_initial_bearing_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [gcib_pkg::LAT_W-1:0] dest_lat,
	input wire logic signed [gcib_pkg::LON_W-1:0] dest_lon,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [gcib_pkg::LON_W-1:0] cfg_data,
	output logic done,
	output logic [gcib_pkg::BRG_W-1:0] bearing
);
	logic signed [gcib_pkg::LAT_W-1:0] ref_lat_q;
	logic signed [gcib_pkg::LON_W-1:0] ref_lon_q;
	gcib_pkg::item_t item_s0;
	logic v_s0, fv;
	logic signed [gcib_pkg::ANG_W-1:0] fa [3];
	logic fn [3];
	logic [3*gcib_pkg::ANG_W+2:0] qin, qout;
	logic qv;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
			v_s0 <= 1'b0;
		end else begin
			v_s0 <= start;
			if (cfg_we) begin
				unique case ({1'b0, cfg_index})
					gcib_pkg::REG_REF_LAT: ref_lat_q <= cfg_data[gcib_pkg::LAT_W-1:0];
					gcib_pkg::REG_REF_LON: ref_lon_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s0.lat2 <= dest_lat;
		item_s0.dlon <= (gcib_pkg::LON_W+1)'(dest_lon)
			- (gcib_pkg::LON_W+1)'(ref_lon_q);
	end

	gcib_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s0), .in_item(item_s0),
		.ref_lat(ref_lat_q), .out_valid(fv), .a_s1(fa), .neg_s1(fn)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qin[k*(gcib_pkg::ANG_W+1) +: gcib_pkg::ANG_W+1] = {fa[k], fn[k]};
		end
	end

	gcib_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(fv), .wr_data(qin),
		.rd_valid(qv), .rd_data(qout)
	);

	gcib_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(qv), .in_data(qout),
		.out_valid(done), .bearing(bearing)
	);
endmodule
`default_nettype wire

// ===== bench/great_circle_initial_bearing_unit_tb.sv =====
// Self-checking bench for great_circle_initial_bearing_unit: directed and random
// target points against a bit-exact bearing predictor, over several reference points.
// Depends on gcib_pkg and the unit itself.
`timescale 1ns / 1ps
`default_nettype none
class bearing_scoreboard;
	localparam int FB = gcib_pkg::ANGLE_FRAC_BITS;
	localparam longint ONE_DEG = longint'(1) << 32;
	localparam longint D90 = 90 * ONE_DEG;
	localparam longint D180 = 180 * ONE_DEG;
	localparam longint D360 = 360 * ONE_DEG;
	localparam longint GAIN = 652032874;

	logic signed [gcib_pkg::LAT_W-1:0] ref_lat;
	logic signed [gcib_pkg::LON_W-1:0] ref_lon;
	logic [gcib_pkg::BRG_W-1:0] pending_bearings[$];
	longint atan_deg[30];
	int errors;

	function new();
		longint unsigned acc;
		longint unsigned term;
		longint unsigned prod;
		int e;
		int k;
		ref_lat = '0;
		ref_lon = '0;
		errors = 0;
		atan_deg[0] = 45 * ONE_DEG;
		// atan(2^-i) as an alternating series, Q30 radians, scaled to degrees
		for (int i = 1; i < 30; i++) begin
			acc = 0;
			k = 0;
			for (e = 62 - i; e >= 0; e = e - 2 * i) begin
				term = (longint'(1) << e) / longint'(2 * k + 1);
				if (k % 2 == 1) acc = acc - term;
				else acc = acc + term;
				k++;
			end
			prod = (acc >> 32) * 64'd15380218700;
			atan_deg[i] = longint'(prod >> 26);
		end
	endfunction

	function void rotate(input longint ang, output longint s, output longint c);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		bit flip;
		x = GAIN;
		y = 0;
		flip = 0;
		z = ang % D360;
		if (z < 0) z += D360;
		if (z >= D180) z -= D360;
		if (z > D90) begin
			z -= D180;
			flip = 1;
		end else if (z < -D90) begin
			z += D180;
			flip = 1;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_deg[i];
			end else begin
				x += dx; y -= dy; z += atan_deg[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function longint vector_angle(input longint yi, input longint xi);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				x = yi; y = -xi; z = D90;
			end else begin
				x = -yi; y = xi; z = -D90;
			end
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_deg[i];
			end else begin
				x -= dx; y += dy; z -= atan_deg[i];
			end
		end
		return z;
	endfunction

	function void note_request(input logic signed [gcib_pkg::LAT_W-1:0] lat2,
			input logic signed [gcib_pkg::LON_W-1:0] lon2);
		longint s1, c1, s2, c2, sd, cd, y, x, z;
		longint unsigned b;
		longint unsigned full;
		rotate(longint'(ref_lat) <<< (32 - FB), s1, c1);
		rotate(longint'(lat2) <<< (32 - FB), s2, c2);
		rotate((longint'(lon2) - longint'(ref_lon)) <<< (32 - FB), sd, cd);
		y = (sd * c2) >>> 30;
		x = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
		z = vector_angle(y, x);
		if (z < 0) z += D360;
		b = (longint'(z) + (longint'(1) << (31 - FB))) >> (32 - FB);
		full = longint'(360) << FB;
		if (b >= full) b -= full;
		pending_bearings.push_back(b[gcib_pkg::BRG_W-1:0]);
	endfunction

	function void check_bearing(input logic [gcib_pkg::BRG_W-1:0] got);
		logic [gcib_pkg::BRG_W-1:0] want;
		if (pending_bearings.size() == 0) begin
			$error("bearing: unexpected result %0d", got);
			errors++;
			return;
		end
		want = pending_bearings.pop_front();
		if (got !== want) begin
			$error("bearing: expected %0d, got %0d", want, got);
			errors++;
		end
	endfunction
endclass

module great_circle_initial_bearing_unit_tb;
	localparam int LAT_W = gcib_pkg::LAT_W;
	localparam int LON_W = gcib_pkg::LON_W;
	localparam int BRG_W = gcib_pkg::BRG_W;
	localparam int LAT_MAX = 5898240;
	localparam int LON_MAX = 11796480;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN = 80;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [LAT_W-1:0] dest_lat;
	logic signed [LON_W-1:0] dest_lon;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [LON_W-1:0] cfg_data;
	logic done;
	logic [BRG_W-1:0] bearing;

	bearing_scoreboard sb;
	bit idle_on;
	int cycles = 0;

	great_circle_initial_bearing_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.dest_lat(dest_lat), .dest_lon(dest_lon),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .bearing(bearing)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial sb = new();

	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_request(dest_lat, dest_lon);
		if (arst_n && done) sb.check_bearing(bearing);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("great_circle_initial_bearing_unit_tb NOT OK");
			$finish;
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [LON_W-1:0] val);
		@(negedge clk);
		start <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == gcib_pkg::REG_REF_LAT[0]) sb.ref_lat = val[LAT_W-1:0];
		else sb.ref_lon = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_reference(input logic signed [LAT_W-1:0] lat,
			input logic signed [LON_W-1:0] lon);
		write_reg(gcib_pkg::REG_REF_LAT[0], LON_W'(lat));
		write_reg(gcib_pkg::REG_REF_LON[0], lon);
	endtask

	task automatic send_request(input logic signed [LAT_W-1:0] lat,
			input logic signed [LON_W-1:0] lon);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 9) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		dest_lat <= lat;
		dest_lon <= lon;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending_bearings.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_requests(input int n);
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
		for (int i = 0; i < n; i++) begin
			// long stretch with no gaps in the middle of each batch
			idle_on = (i < n / 3) || (i > 2 * n / 3);
			if ($urandom_range(0, 9) == 0) begin
				lat = LAT_W'($urandom);
				lon = LON_W'($urandom);
			end else begin
				lat = LAT_W'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
				lon = LON_W'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
			end
			send_request(lat, lon);
		end
	endtask

	initial begin
		logic signed [LAT_W-1:0] rl;
		logic signed [LON_W-1:0] rn;
		arst_n = 1'b0;
		start = 1'b0;
		dest_lat = '0;
		dest_lon = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: poles, equator, antimeridian, same point, out of range
		idle_on = 1'b0;
		send_request(LAT_W'(0), LON_W'(0));
		send_request(LAT_W'(LAT_MAX), LON_W'(0));
		send_request(LAT_W'(-LAT_MAX), LON_W'(0));
		send_request(LAT_W'(0), LON_W'(LON_MAX));
		send_request(LAT_W'(0), LON_W'(-LON_MAX));
		send_request(LAT_W'(LAT_MAX), LON_W'(LON_MAX));
		send_request(LAT_W'(-LAT_MAX), LON_W'(-LON_MAX));
		send_request(LAT_W'(0), LON_W'(90 <<< 16));
		send_request(LAT_W'(0), LON_W'(-(90 <<< 16)));
		send_request(LAT_W'(45 <<< 16), LON_W'(1));
		send_request(24'h7fffff, 25'h0ffffff);
		send_request(24'h800000, 25'h1000000);
		send_request(24'hffffff, 25'h1ffffff);
		settle();

		set_reference(LAT_W'(LAT_MAX), LON_W'(LON_MAX));
		send_request(LAT_W'(LAT_MAX), LON_W'(LON_MAX));
		send_request(LAT_W'(-LAT_MAX), LON_W'(-LON_MAX));
		send_request(LAT_W'(0), LON_W'(0));
		settle();
		set_reference(LAT_W'(-LAT_MAX), LON_W'(-LON_MAX));
		send_request(LAT_W'(-LAT_MAX), LON_W'(-LON_MAX));
		send_request(LAT_W'(10 <<< 16), LON_W'(20 <<< 16));
		random_requests(150);
		settle();

		set_reference(24'h7fffff, 25'h0ffffff);
		random_requests(150);
		settle();
		set_reference(24'h800000, 25'h1000000);
		random_requests(150);
		settle();
		set_reference(LAT_W'(0), LON_W'(0));
		random_requests(150);
		settle();
		for (int p = 0; p < 2; p++) begin
			rl = LAT_W'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
			rn = LON_W'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
			set_reference(rl, rn);
			send_request(rl, rn);
			random_requests(170);
			settle();
		end

		if (sb.errors == 0 && sb.pending_bearings.size() == 0) begin
			$display("great_circle_initial_bearing_unit_tb OK");
		end else begin
			$display("great_circle_initial_bearing_unit_tb NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire
